### sv/nsrp_pkg.sv
// ----------------------------------------------------------------------------
// nsrp_pkg: shared types and constants of the segment picker
// Field widths, fixed-point formats, register codes and transaction structs.
// ----------------------------------------------------------------------------
package nsrp_pkg;

	// run limit; later segments of an over-long run are ignored
	localparam int MAX_SEGMENTS = 1024;

	localparam int POS_W      = 32;             // Q16.16 positions
	localparam int FWD_W      = 16;             // Q2.14 forward vector
	localparam int DIST_W     = 31;             // Q15.16 unsigned distance
	localparam int IDX_W      = 10;             // run position of the pick
	localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// datapath widths
	localparam int DIFF_W = POS_W + 1;          // endpoint minus camera
	localparam int VEC_W  = POS_W + 2;          // sum / difference of two diffs
	localparam int MUL_W  = VEC_W + 1;          // shared multiplier operand
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 66;                 // sums of three products
	localparam int CR_W   = 52;                 // cross components, Q.30
	localparam int NM_W   = CR_W - 1;           // normal magnitudes
	localparam int SQ_W   = 64;                 // root / divide operand
	localparam int ROOT_W = SQ_W / 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [DIST_W-1:0] DMAX         = '1;
	localparam logic [DIST_W-1:0] MAX_DIST_RST = DIST_W'(65536);
	localparam logic [FWD_W-1:0]  FWD_Z_RST    = FWD_W'(16384);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_X,
		REG_CAM_Y,
		REG_CAM_Z,
		REG_FWD_X,
		REG_FWD_Y,
		REG_FWD_Z,
		REG_MAX_DIST
	} cfg_reg_t;

	// input transaction
	typedef struct packed {
		logic signed [POS_W-1:0] p1_x;
		logic signed [POS_W-1:0] p1_y;
		logic signed [POS_W-1:0] p1_z;
		logic signed [POS_W-1:0] p2_x;
		logic signed [POS_W-1:0] p2_y;
		logic signed [POS_W-1:0] p2_z;
		logic                    is_last;
	} seg_t;

	// result transaction
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  picked_index;
		logic [DIST_W-1:0] picked_distance;
	} pick_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos3_t;

	typedef struct packed {
		logic signed [FWD_W-1:0] x;
		logic signed [FWD_W-1:0] y;
		logic signed [FWD_W-1:0] z;
	} fwd3_t;

	// classified segment waiting between front and back
	typedef struct packed {
		logic [2:0][DIFF_W-1:0] t1;     // p1 - cam
		logic [2:0][DIFF_W-1:0] t2;     // p2 - cam
		logic [IDX_W-1:0]       idx;
		logic                   first;  // opens a run
		logic                   skip;   // beyond the run limit
		logic                   last;
	} entry_t;

	function automatic logic [DIFF_W-1:0] pdiff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
		return {a[POS_W-1], a} - {b[POS_W-1], b};
	endfunction

endpackage

### sv/nsrp_front.sv
// ----------------------------------------------------------------------------
// nsrp_front: accept and classify segments
// Forms camera-relative endpoints, tags run position, and queues the result.
// ----------------------------------------------------------------------------
module nsrp_front import nsrp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  pos3_t  cam,
	input  logic   push,
	input  seg_t   seg,
	output logic   full,
	input  logic   deq,
	output logic   avail,
	output entry_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [QC_W-1:0]  qcnt_q;
	entry_t           q_mem [QUEUE_DEPTH];
	entry_t           new_ent;
	logic             accept;

	assign accept = push && !full;
	assign full   = (qcnt_q == QC_W'(QUEUE_DEPTH));
	assign avail  = (qcnt_q != '0);
	assign head   = q_mem[rd_q];

	// classify the incoming segment
	always_comb begin
		new_ent.t1[0] = pdiff(seg.p1_x, cam.x);
		new_ent.t1[1] = pdiff(seg.p1_y, cam.y);
		new_ent.t1[2] = pdiff(seg.p1_z, cam.z);
		new_ent.t2[0] = pdiff(seg.p2_x, cam.x);
		new_ent.t2[1] = pdiff(seg.p2_y, cam.y);
		new_ent.t2[2] = pdiff(seg.p2_z, cam.z);
		new_ent.idx   = IDX_W'(cnt_q);
		new_ent.first = (cnt_q == '0);
		new_ent.skip  = (cnt_q >= CNT_W'(MAX_SEGMENTS));
		new_ent.last  = seg.is_last;
	end

	// run counter and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			qcnt_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + PTR_W'(1);
				if (seg.is_last)
					cnt_q <= '0;
				else if (!new_ent.skip)
					cnt_q <= cnt_q + CNT_W'(1);
			end
			if (deq)
				rd_q <= rd_q + PTR_W'(1);
			if (accept && !deq)
				qcnt_q <= qcnt_q + QC_W'(1);
			else if (!accept && deq)
				qcnt_q <= qcnt_q - QC_W'(1);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (accept)
			q_mem[wr_q] <= new_ent;
	end

endmodule

### sv/nsrp_isqrt.sv
// ----------------------------------------------------------------------------
// nsrp_isqrt: bit-pair integer square root
// Floor root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module nsrp_isqrt import nsrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   x_in,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int STEPS  = SQ_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	logic [SQ_W-1:0]   x_q, r_q, b_q;
	logic [STEP_W-1:0] n_q;
	logic              busy_q, done_q;
	logic [SQ_W:0]     trial;
	logic              ge;

	assign trial = {1'b0, r_q} + {1'b0, b_q};
	assign ge    = ({1'b0, x_q} >= trial);
	assign done  = done_q;
	assign root  = r_q[ROOT_W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= '0;
			end else if (busy_q) begin
				n_q <= n_q + STEP_W'(1);
				if (n_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one root bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in;
			r_q <= '0;
			b_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				x_q <= x_q - trial[SQ_W-1:0];
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

endmodule

### sv/nsrp_div.sv
// ----------------------------------------------------------------------------
// nsrp_div: restoring divider
// 64-bit by 32-bit unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsrp_div import nsrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   dividend,
	input  logic [ROOT_W-1:0] divisor,
	output logic              done,
	output logic [SQ_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(SQ_W);

	logic [SQ_W-1:0]   dvd_q;
	logic [ROOT_W-1:0] dvs_q, rem_q;
	logic [STEP_W-1:0] n_q;
	logic              busy_q, done_q;
	logic [ROOT_W:0]   rem_sh, rem_sub;
	logic              ge;

	assign rem_sh   = {rem_q, dvd_q[SQ_W-1]};
	assign rem_sub  = rem_sh - {1'b0, dvs_q};
	assign ge       = (rem_sh >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = dvd_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= '0;
			end else if (busy_q) begin
				n_q <= n_q + STEP_W'(1);
				if (n_q == STEP_W'(SQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SQ_W-2:0], ge};
			rem_q <= ge ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
		end
	end

endmodule

### sv/nsrp_back.sv
// ----------------------------------------------------------------------------
// nsrp_back: distance sequencer and run tracker
// Shared multiplier, root and divide units work one segment at a time.
// ----------------------------------------------------------------------------
module nsrp_back import nsrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fwd3_t             fwd,
	input  logic [DIST_W-1:0] max_dist,
	input  logic              avail,
	input  entry_t            head,
	output logic              deq,
	output logic              res_vld,
	input  logic              res_rdy,
	output pick_t             res
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PROD, ST_DRAIN, ST_CHK, ST_RND, ST_SQ, ST_SQRT, ST_NRM0,
		ST_NRM, ST_LSQ, ST_LDOT, ST_LSQRT, ST_DIV, ST_DEC, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_DOT, DST_CR, DST_SQ, DST_LDOT
	} dst_t;

	typedef struct packed {
		logic       vld;
		logic       neg;
		logic       clr;
		dst_t       dst;
		logic [1:0] grp;
		logic [1:0] comp;
	} tag_t;

	// product groups: two dot products, then four cross products
	localparam logic [2:0] G_DOT1  = 3'd0;
	localparam logic [2:0] G_DOT2  = 3'd1;
	localparam logic [2:0] G_CR_T1 = 3'd2;
	localparam logic [2:0] G_CR_T2 = 3'd3;
	localparam logic [2:0] G_CR_SM = 3'd4;
	localparam logic [2:0] G_CR_DF = 3'd5;

	localparam logic [1:0] LAST_COMP = 2'd2;
	localparam logic [1:0] MID_RAY   = 2'd2;
	localparam int         NORM_HI   = 28;

	state_t            state_q;
	logic [2:0]        grp_q;
	logic [1:0]        comp_q, ray_q;
	logic              term_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              have_q;

	entry_t                  ent_q;
	logic signed [CR_W-1:0]  dot_q [2];
	logic signed [CR_W-1:0]  cr_q  [4][3];
	logic [DIST_W-1:0]       rc_q  [3];
	logic [DIST_W-1:0]       e_q   [3];
	logic [NM_W-1:0]         nm_q  [3];
	logic [NM_W-1:0]         m_q;
	logic [DIST_W-1:0]       ln_q;
	logic signed [ACC_W-1:0] ldot_q, acc_q, prod_s1;
	tag_t                    tag_s1;

	tag_t                    iss;
	logic signed [MUL_W-1:0] iss_a, iss_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_base, acc_nx;

	logic              sq_start, sq_done, dv_start, dv_done;
	logic [ROOT_W-1:0] sq_root;
	logic [SQ_W-1:0]   dv_quot;
	logic [ACC_W-1:0]  lmag;

	logic [CR_W-1:0]   rmag [3];
	logic [CR_W:0]     rnd  [3];
	logic [CR_W:0]     rsh  [3];
	logic [2:0]        rsat;
	logic [NM_W-1:0]   nmag [3];
	logic [NM_W-1:0]   m01, nmax;
	logic [DIST_W-1:0] emin, cand_dist;
	logic              behind;

	function automatic logic signed [MUL_W-1:0] fcomp(fwd3_t f, logic [1:0] c);
		case (c)
			2'd0:    return MUL_W'(f.x);
			2'd1:    return MUL_W'(f.y);
			2'd2:    return MUL_W'(f.z);
			default: return MUL_W'(f.x);
		endcase
	endfunction

	function automatic logic signed [MUL_W-1:0] vcomp(entry_t e, logic [2:0] g, logic [1:0] c);
		logic signed [VEC_W-1:0] a, b;
		a = VEC_W'($signed(e.t1[c]));
		b = VEC_W'($signed(e.t2[c]));
		case (g)
			G_DOT1, G_CR_T1: return MUL_W'(a);
			G_DOT2, G_CR_T2: return MUL_W'(b);
			G_CR_SM:         return MUL_W'(a + b);
			G_CR_DF:         return MUL_W'(b - a);
			default:         return MUL_W'(a);
		endcase
	endfunction

	function automatic logic [1:0] nxt1(logic [1:0] c);
		return (c == LAST_COMP) ? 2'd0 : c + 2'd1;
	endfunction

	function automatic logic [1:0] nxt2(logic [1:0] c);
		return (c == 2'd0) ? LAST_COMP : c - 2'd1;
	endfunction

	// product issue: operand selection per sequencer step
	always_comb begin
		iss   = '0;
		iss_a = '0;
		iss_b = '0;
		case (state_q)
			ST_PROD: begin
				iss.vld  = 1'b1;
				iss.comp = comp_q;
				if (grp_q < G_CR_T1) begin
					iss_a   = fcomp(fwd, comp_q);
					iss_b   = vcomp(ent_q, grp_q, comp_q);
					iss.clr = (comp_q == 2'd0);
					iss.dst = (comp_q == LAST_COMP) ? DST_DOT : DST_NONE;
					iss.grp = grp_q[1:0];
				end else begin
					// c[k] = f[k+1]*v[k+2] - f[k+2]*v[k+1]
					iss_a   = fcomp(fwd, term_q ? nxt2(comp_q) : nxt1(comp_q));
					iss_b   = vcomp(ent_q, grp_q, term_q ? nxt1(comp_q) : nxt2(comp_q));
					iss.neg = term_q;
					iss.clr = !term_q;
					iss.dst = term_q ? DST_CR : DST_NONE;
					iss.grp = 2'(grp_q - G_CR_T1);
				end
			end
			ST_SQ: begin
				iss.vld = 1'b1;
				iss_a   = MUL_W'(rc_q[comp_q]);
				iss_b   = MUL_W'(rc_q[comp_q]);
				iss.clr = (comp_q == 2'd0);
				iss.dst = (comp_q == LAST_COMP) ? DST_SQ : DST_NONE;
			end
			ST_LSQ: begin
				iss.vld = 1'b1;
				iss_a   = MUL_W'(nm_q[comp_q]);
				iss_b   = MUL_W'(nm_q[comp_q]);
				iss.clr = (comp_q == 2'd0);
				iss.dst = (comp_q == LAST_COMP) ? DST_SQ : DST_NONE;
			end
			ST_LDOT: begin
				// (cam - p1) = -t1, so add where the normal component is negative
				iss.vld = 1'b1;
				iss_a   = MUL_W'(nm_q[comp_q]);
				iss_b   = MUL_W'($signed(ent_q.t1[comp_q]));
				iss.neg = !cr_q[3][comp_q][CR_W-1];
				iss.clr = (comp_q == 2'd0);
				iss.dst = (comp_q == LAST_COMP) ? DST_LDOT : DST_NONE;
			end
			default: ;
		endcase
	end

	assign prod = iss_a * iss_b;

	// accumulate stage
	assign acc_base = tag_s1.clr ? '0 : acc_q;
	assign acc_nx   = tag_s1.neg ? acc_base - prod_s1 : acc_base + prod_s1;
	assign sq_start = tag_s1.vld && (tag_s1.dst == DST_SQ);

	// ray distance rounding of one cross product
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rmag[c] = cr_q[ray_q][c][CR_W-1] ? CR_W'(-cr_q[ray_q][c]) : CR_W'(cr_q[ray_q][c]);
			if (ray_q == MID_RAY) begin
				rnd[c] = {1'b0, rmag[c]} + ((CR_W+1)'(1) << 14);
				rsh[c] = rnd[c] >> 15;
			end else begin
				rnd[c] = {1'b0, rmag[c]} + ((CR_W+1)'(1) << 13);
				rsh[c] = rnd[c] >> 14;
			end
			rsat[c] = |rsh[c][CR_W:DIST_W];
		end
	end

	// normal magnitudes and their maximum
	always_comb begin
		for (int c = 0; c < 3; c++)
			nmag[c] = cr_q[3][c][CR_W-1] ? NM_W'(-cr_q[3][c]) : NM_W'(cr_q[3][c]);
		m01  = (nmag[0] > nmag[1]) ? nmag[0] : nmag[1];
		nmax = (nmag[2] > m01) ? nmag[2] : m01;
	end

	// final selection
	assign behind = (dot_q[0][CR_W-1] || dot_q[0] == '0) && (dot_q[1][CR_W-1] || dot_q[1] == '0);
	assign emin      = (e_q[0] < e_q[1]) ? e_q[0] : e_q[1];
	assign cand_dist = (emin < ln_q || emin < e_q[2]) ? emin : ln_q;

	assign lmag     = ldot_q[ACC_W-1] ? ACC_W'(-ldot_q) : ACC_W'(ldot_q);
	assign dv_start = (state_q == ST_LSQRT) && sq_done;

	assign deq     = (state_q == ST_IDLE) && avail;
	assign res_vld = (state_q == ST_FIN) && ent_q.last;
	assign res.found           = have_q;
	assign res.picked_index    = have_q ? best_idx_q : '0;
	assign res.picked_distance = best_dist_q;

	nsrp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x_in   (SQ_W'(acc_nx)),
		.done   (sq_done),
		.root   (sq_root)
	);

	nsrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (SQ_W'(lmag)),
		.divisor  (sq_root),
		.done     (dv_done),
		.quotient (dv_quot)
	);

	// sequencer state and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grp_q       <= G_DOT1;
			comp_q      <= '0;
			term_q      <= 1'b0;
			ray_q       <= '0;
			best_dist_q <= '0;
			best_idx_q  <= '0;
			have_q      <= 1'b0;
			tag_s1      <= '0;
		end else begin
			tag_s1 <= iss;
			case (state_q)
				ST_IDLE: begin
					if (avail) begin
						if (head.first) begin
							best_dist_q <= max_dist;
							best_idx_q  <= '0;
							have_q      <= 1'b0;
						end
						grp_q   <= G_DOT1;
						comp_q  <= '0;
						term_q  <= 1'b0;
						state_q <= head.skip ? ST_FIN : ST_PROD;
					end
				end
				ST_PROD: begin
					if (grp_q < G_CR_T1) begin
						if (comp_q == LAST_COMP) begin
							comp_q <= '0;
							grp_q  <= grp_q + 3'd1;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						term_q <= !term_q;
						if (term_q) begin
							if (comp_q == LAST_COMP) begin
								comp_q <= '0;
								if (grp_q == G_CR_DF)
									state_q <= ST_DRAIN;
								else
									grp_q <= grp_q + 3'd1;
							end else begin
								comp_q <= comp_q + 2'd1;
							end
						end
					end
				end
				ST_DRAIN: state_q <= ST_CHK;
				ST_CHK: begin
					ray_q   <= '0;
					state_q <= behind ? ST_FIN : ST_RND;
				end
				ST_RND: begin
					comp_q <= '0;
					if (|rsat) begin
						if (ray_q == MID_RAY) begin
							state_q <= ST_NRM0;
						end else begin
							ray_q   <= ray_q + 2'd1;
							state_q <= ST_RND;
						end
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					comp_q <= comp_q + 2'd1;
					if (comp_q == LAST_COMP)
						state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_done) begin
						if (ray_q == MID_RAY) begin
							state_q <= ST_NRM0;
						end else begin
							ray_q   <= ray_q + 2'd1;
							state_q <= ST_RND;
						end
					end
				end
				ST_NRM0: state_q <= (nmax == '0) ? ST_DEC : ST_NRM;
				ST_NRM: begin
					if (m_q < NM_W'(1) << NORM_HI && m_q[NORM_HI-1]) begin
						comp_q  <= '0;
						state_q <= ST_LSQ;
					end
				end
				ST_LSQ: begin
					if (comp_q == LAST_COMP) begin
						comp_q  <= '0;
						state_q <= ST_LDOT;
					end else begin
						comp_q <= comp_q + 2'd1;
					end
				end
				ST_LDOT: begin
					comp_q <= comp_q + 2'd1;
					if (comp_q == LAST_COMP)
						state_q <= ST_LSQRT;
				end
				ST_LSQRT: if (sq_done) state_q <= ST_DIV;
				ST_DIV:   if (dv_done) state_q <= ST_DEC;
				ST_DEC: begin
					if (cand_dist < best_dist_q) begin
						best_dist_q <= cand_dist;
						best_idx_q  <= ent_q.idx;
						have_q      <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!ent_q.last) begin
						state_q <= ST_IDLE;
					end else if (res_rdy) begin
						best_idx_q <= '0;
						have_q     <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (deq)
			ent_q <= head;
		prod_s1 <= ACC_W'(prod);
		if (tag_s1.vld) begin
			acc_q <= acc_nx;
			case (tag_s1.dst)
				DST_DOT:  dot_q[tag_s1.grp[0]] <= CR_W'(acc_nx);
				DST_CR:   cr_q[tag_s1.grp][tag_s1.comp] <= CR_W'(acc_nx);
				DST_LDOT: ldot_q <= acc_nx;
				default:  ;
			endcase
		end
		if (state_q == ST_RND) begin
			for (int c = 0; c < 3; c++)
				rc_q[c] <= rsh[c][DIST_W-1:0];
			if (|rsat)
				e_q[ray_q] <= DMAX;
		end
		if (state_q == ST_SQRT && sq_done)
			e_q[ray_q] <= sq_root[ROOT_W-1] ? DMAX : sq_root[DIST_W-1:0];
		if (state_q == ST_NRM0) begin
			for (int c = 0; c < 3; c++)
				nm_q[c] <= nmag[c];
			m_q <= nmax;
			if (nmax == '0)
				ln_q <= DMAX;
		end
		// bring the largest normal magnitude into [2^27, 2^28)
		if (state_q == ST_NRM) begin
			if (|m_q[NM_W-1:NORM_HI]) begin
				for (int c = 0; c < 3; c++)
					nm_q[c] <= nm_q[c] >> 1;
				m_q <= m_q >> 1;
			end else if (!m_q[NORM_HI-1]) begin
				for (int c = 0; c < 3; c++)
					nm_q[c] <= nm_q[c] << 1;
				m_q <= m_q << 1;
			end
		end
		if (state_q == ST_DIV && dv_done)
			ln_q <= (|dv_quot[SQ_W-1:DIST_W]) ? DMAX : dv_quot[DIST_W-1:0];
	end

endmodule

### sv/nearest_segment_to_ray_picker.sv
// ----------------------------------------------------------------------------
// nearest_segment_to_ray_picker: closest segment to a view ray
// Configuration registers, front classifier, back sequencer, result register.
// ----------------------------------------------------------------------------
// Back-end steps for a segment in front of the ray: the dot and cross products
// and the behind check, the endpoint and midpoint roots, the line distance
// (normalize, root, divide) and the decision; a saturated ray skips its root
// and a zero normal skips the line distance. A segment behind the ray stops
// after the check; an over-limit segment skips all steps. Throughput is one
// segment per back-end pass; the front queues two more. Reset: async
// active low; config to defaults, queue and result empty.
module nearest_segment_to_ray_picker import nsrp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  push,
	input  seg_t                  seg,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output pick_t                 pick
);

	pos3_t             cam_q;
	fwd3_t             fwd_q;
	logic [DIST_W-1:0] max_dist_q;
	logic              avail, deq, res_vld, res_rdy, out_vld_q;
	entry_t            head;
	pick_t             res, out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q      <= '0;
			fwd_q.x    <= '0;
			fwd_q.y    <= '0;
			fwd_q.z    <= FWD_Z_RST;
			max_dist_q <= MAX_DIST_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_CAM_X:    cam_q.x    <= wr_data[POS_W-1:0];
				REG_CAM_Y:    cam_q.y    <= wr_data[POS_W-1:0];
				REG_CAM_Z:    cam_q.z    <= wr_data[POS_W-1:0];
				REG_FWD_X:    fwd_q.x    <= wr_data[FWD_W-1:0];
				REG_FWD_Y:    fwd_q.y    <= wr_data[FWD_W-1:0];
				REG_FWD_Z:    fwd_q.z    <= wr_data[FWD_W-1:0];
				REG_MAX_DIST: max_dist_q <= wr_data[DIST_W-1:0];
				default:      ;
			endcase
		end
	end

	nsrp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cam    (cam_q),
		.push   (push),
		.seg    (seg),
		.full   (full),
		.deq    (deq),
		.avail  (avail),
		.head   (head)
	);

	nsrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fwd      (fwd_q),
		.max_dist (max_dist_q),
		.avail    (avail),
		.head     (head),
		.deq      (deq),
		.res_vld  (res_vld),
		.res_rdy  (res_rdy),
		.res      (res)
	);

	// result register
	assign res_rdy = !out_vld_q || pop;
	assign empty   = !out_vld_q;
	assign pick    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_vld && res_rdy) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_rdy)
			out_q <= res;
	end

endmodule

### sv/nsrp_checker.sv
// ----------------------------------------------------------------------------
// nsrp_checker: port-level checks of the segment picker
// Result queue behavior and consistency of the reported pick.
// ----------------------------------------------------------------------------
module nsrp_checker import nsrp_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  full,
	input logic  empty,
	input logic  pop,
	input pick_t pick
);

	// both queues read empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> (!full && empty))
		else $error("queues not empty in reset");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pick)))
		else $error("waiting result changed");

	// no pick reports index zero
	a_none_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pick.found) |-> (pick.picked_index == '0))
		else $error("index set without pick");

	// a saturated distance is never picked
	a_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pick.found) |-> (pick.picked_distance != DMAX))
		else $error("saturated distance picked");

endmodule

bind nearest_segment_to_ray_picker nsrp_checker u_nsrp_checker (.*);
